>>> rtl/spm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SCOPE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_SPLIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AUDIO_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PX     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_PX    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_COS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_SIN      = 3'd6;

    // queue depths; RES_DEPTH must cover the back pipeline latency
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 16;

    // latency of the placement pipe (magnitude to screen coordinate)
    localparam int PLACE_LAT = 8;

    localparam logic signed [32:0] UNIT_Q26      = 33'sd67108864;
    localparam logic [15:0]        INV_SQRT2_Q16 = 16'd46341;
    // ceil(2^23 / 10), exact for dividends below 2^22
    localparam logic [19:0]        RECIP_TEN     = 20'd838861;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [9:0]         idx;
        logic               vec_mode;
    } job_t;

    typedef struct packed {
        logic [9:0]  point_index;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic        last_of_run;
    } res_t;

    typedef struct packed {
        logic               split;
        logic [15:0]        gain;
        logic [11:0]        weff;
        logic [11:0]        heff;
        logic [11:0]        minwh;
        logic signed [15:0] rot_cos;
        logic signed [15:0] rot_sin;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/spm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module spm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             wr_ok;
    logic             rd_ok;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_ok = wr_en && !full;
    assign rd_ok = rd_en && !empty;

    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(wr_ok) - CW'(rd_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/spm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spm_front #(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic [9:0]         sample_index,
    input  logic               vec_mode,
    output logic               job_wr,
    output spm_pkg::job_t      job,
    input  logic               job_full
);

    import spm_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    logic hold_keep_reg, hold_keep_next;
    job_t hold_job_reg;
    logic accept;
    logic move;
    logic keep_in;

    // out-of-frame indices and odd oscilloscope indices make no points
    assign keep_in = (int'(sample_index) < SAMPLES_PER_FRAME)
                     && (vec_mode || !sample_index[0]);

    assign move   = hold_valid_reg && (!hold_keep_reg || !job_full);
    assign full   = hold_valid_reg && !move;
    assign accept = push && !full;
    assign job_wr = hold_valid_reg && hold_keep_reg && !job_full;
    assign job    = hold_job_reg;

    always_comb
    begin
        hold_valid_next = accept || (hold_valid_reg && !move);
        hold_keep_next  = accept ? keep_in : hold_keep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_keep_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            hold_keep_reg  <= hold_keep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_job_reg.left     <= left_sample;
            hold_job_reg.right    <= right_sample;
            hold_job_reg.idx      <= sample_index;
            hold_job_reg.vec_mode <= vec_mode;
        end
    end

endmodule

`default_nettype wire

>>> rtl/spm_place.sv
`timescale 1ns / 1ps
`default_nettype none

// centre +- 0.45*minwh*min(|v|/sqrt2, 1), Q.4, rounding on the magnitude
module spm_place (
    input  logic               clk,
    input  logic signed [50:0] v,
    input  logic [14:0]        centre,
    input  logic [11:0]        minwh,
    output logic [15:0]        pos
);

    import spm_pkg::*;

    localparam logic [42:0] MAG_SAT = 43'd1 << 42;
    localparam logic [40:0] P_SAT   = 41'd1 << 40;

    logic        neg_reg [1:PLACE_LAT-1];
    logic [42:0] m_reg;
    logic [37:0] mlo_reg;
    logic [36:0] mhi_reg;
    logic [40:0] p_reg;
    logic [31:0] qlo_reg;
    logic [32:0] qhi_reg;
    logic [52:0] xw_reg;
    logic [18:0] ysc_reg;
    logic [38:0] yq_reg;
    logic [15:0] pos_reg;

    logic [50:0] mag;
    logic [42:0] m_sat;
    logic [59:0] psum;
    logic [43:0] pp;
    logic [40:0] p_sat;
    logic [59:0] t72;
    logic [15:0] off;

    always_comb
    begin
        mag   = v[50] ? 51'(-v) : 51'(v);
        m_sat = (mag > 51'(MAG_SAT)) ? MAG_SAT : 43'(mag);
        psum  = 60'({mhi_reg, 22'b0}) + 60'(mlo_reg) + 60'd32768;
        pp    = psum[59:16];
        p_sat = (pp > 44'(P_SAT)) ? P_SAT : 41'(pp);
        // x*72 as x*64 + x*8
        t72   = 60'({xw_reg, 6'b0}) + 60'({xw_reg, 3'b0});
        off   = yq_reg[38:23];
    end

    always_ff @(posedge clk)
    begin
        neg_reg[1] <= v[50];
        for (int i = 2; i < PLACE_LAT; i++)
        begin
            neg_reg[i] <= neg_reg[i-1];
        end
        m_reg   <= m_sat;
        // 1/sqrt2 product split in two halves
        mlo_reg <= 38'(m_reg[21:0]) * 38'(INV_SQRT2_Q16);
        mhi_reg <= 37'(m_reg[42:22]) * 37'(INV_SQRT2_Q16);
        p_reg   <= p_sat;
        qlo_reg <= 32'(p_reg[19:0]) * 32'(minwh);
        qhi_reg <= 33'(p_reg[40:20]) * 33'(minwh);
        xw_reg  <= 53'({qhi_reg, 20'b0}) + 53'(qlo_reg);
        // floor(72*x/2^40) + 5, then /10 by reciprocal
        ysc_reg <= 19'(t72[59:40]) + 19'd5;
        yq_reg  <= 39'(ysc_reg) * 39'(RECIP_TEN);
        pos_reg <= neg_reg[PLACE_LAT-1] ? 16'(centre) - off : 16'(centre) + off;
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

>>> rtl/spm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spm_back #(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spm_pkg::cfg_t cfg,
    input  spm_pkg::job_t job,
    input  logic          job_empty,
    output logic          job_pop,
    input  logic          res_taken,
    output logic          res_wr,
    output spm_pkg::res_t res
);

    import spm_pkg::*;

    localparam int              HALF = SAMPLES_PER_FRAME / 2;
    localparam int              DX   = 2 * (HALF - 1);
    localparam longint unsigned RX   = (64'd1 << 27) / DX;
    localparam int              LAT  = 5 + PLACE_LAT;
    localparam int              CW   = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic       vec;
        logic       side;
        logic [9:0] pidx;
        logic       last;
    } meta_t;

    // issue control
    logic          phase_reg, phase_next;
    logic [CW-1:0] credit_reg, credit_next;
    logic          issue;
    logic [8:0]    k;
    meta_t         meta_in;

    // pipeline
    logic               vld_reg [1:LAT];
    meta_t              meta_reg [1:LAT];
    logic signed [15:0] l_s1_reg, r_s1_reg;
    logic [8:0]         k_s1_reg;
    logic signed [32:0] gl_s2_reg, gr_s2_reg;
    logic [20:0]        kw_s2_reg;
    logic [28:0]        ya_s3_reg;
    logic signed [33:0] d_s3_reg, m_s3_reg;
    logic [25:0]        nx_s3_reg, nx_s4_reg, nx_s5_reg, nx_s6_reg;
    logic [40:0]        yp_s4_reg;
    logic [52:0]        np_s4_reg;
    logic signed [49:0] pdc_s4_reg, pms_s4_reg, pds_s4_reg, pmc_s4_reg;
    logic [25:0]        q0_s5_reg, q0_s6_reg;
    logic signed [50:0] vx_s5_reg, vy_s5_reg;
    logic [26:0]        qd_s6_reg;
    logic [15:0]        oy_reg [5:LAT];
    logic [15:0]        ox_reg [7:LAT];

    logic signed [32:0] g_sel;
    logic signed [32:0] g_clamp;
    logic [27:0]        a_val;
    logic [26:0]        rem;
    logic [15:0]        px, py;

    // ---------------- issue ----------------
    assign k     = job.idx[9:1];
    assign issue = !job_empty && ((credit_reg < CW'(RES_DEPTH)) || res_taken);

    always_comb
    begin
        meta_in.vec  = job.vec_mode;
        meta_in.side = phase_reg && !job.vec_mode;
        meta_in.pidx = job.idx;
        meta_in.last = 1'b1;
        phase_next   = phase_reg;
        job_pop      = 1'b0;
        priority if (job.vec_mode)
        begin
            job_pop = issue;
        end
        else if (!phase_reg)
        begin
            // left point first
            meta_in.pidx = {1'b0, k};
            meta_in.last = 1'b0;
            phase_next   = issue;
        end
        else
        begin
            meta_in.pidx = 10'(HALF) + {1'b0, k};
            job_pop      = issue;
            phase_next   = !issue;
        end
        // credits count points in flight plus words queued at the output
        credit_next = credit_reg + CW'(issue) - CW'(res_taken);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            credit_reg <= '0;
            for (int i = 1; i <= LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            credit_reg <= credit_next;
            vld_reg[1] <= issue;
            for (int i = 2; i <= LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        g_sel = meta_reg[2].side ? gr_s2_reg : gl_s2_reg;
        priority if (g_sel > UNIT_Q26)
        begin
            g_clamp = UNIT_Q26;
        end
        else if (g_sel < -UNIT_Q26)
        begin
            g_clamp = -UNIT_Q26;
        end
        else
        begin
            g_clamp = g_sel;
        end
        a_val = 28'(g_clamp + UNIT_Q26);
        rem   = 27'(nx_s6_reg) - qd_s6_reg;
    end

    always_ff @(posedge clk)
    begin
        meta_reg[1] <= meta_in;
        for (int i = 2; i <= LAT; i++)
        begin
            meta_reg[i] <= meta_reg[i-1];
        end

        // s1
        l_s1_reg <= job.left;
        r_s1_reg <= job.right;
        k_s1_reg <= k;

        // s2: gain, Q.26
        gl_s2_reg <= l_s1_reg * $signed({1'b0, cfg.gain});
        gr_s2_reg <= r_s1_reg * $signed({1'b0, cfg.gain});
        kw_s2_reg <= 21'(k_s1_reg) * 21'(cfg.weff);

        // s3
        ya_s3_reg <= 29'(a_val)
                     + ((cfg.split && !meta_reg[2].side) ? 29'd134217728 : 29'd0);
        d_s3_reg  <= 34'(gl_s2_reg) - 34'(gr_s2_reg);
        m_s3_reg  <= 34'(gl_s2_reg) + 34'(gr_s2_reg);
        nx_s3_reg <= 26'({kw_s2_reg, 5'b0}) + 26'(HALF - 1);

        // s4
        yp_s4_reg  <= 41'(ya_s3_reg) * 41'(cfg.heff);
        np_s4_reg  <= 53'(nx_s3_reg) * 53'(RX);
        nx_s4_reg  <= nx_s3_reg;
        pdc_s4_reg <= d_s3_reg * cfg.rot_cos;
        pms_s4_reg <= m_s3_reg * cfg.rot_sin;
        pds_s4_reg <= d_s3_reg * cfg.rot_sin;
        pmc_s4_reg <= m_s3_reg * cfg.rot_cos;

        // s5
        oy_reg[5] <= cfg.split ? 16'((yp_s4_reg + 41'd8388608) >> 24)
                               : 16'((yp_s4_reg + 41'd4194304) >> 23);
        q0_s5_reg <= 26'(np_s4_reg >> 27);
        nx_s5_reg <= nx_s4_reg;
        vx_s5_reg <= 51'(pdc_s4_reg) - 51'(pms_s4_reg);
        vy_s5_reg <= 51'(pds_s4_reg) + 51'(pmc_s4_reg);

        // s6: quotient estimate is floor or one below
        qd_s6_reg <= 27'(38'(q0_s5_reg) * 38'(DX));
        q0_s6_reg <= q0_s5_reg;
        nx_s6_reg <= nx_s5_reg;

        // s7
        ox_reg[7] <= (rem >= 27'(DX)) ? 16'(q0_s6_reg + 26'd1) : 16'(q0_s6_reg);

        for (int i = 6; i <= LAT; i++)
        begin
            oy_reg[i] <= oy_reg[i-1];
        end
        for (int i = 8; i <= LAT; i++)
        begin
            ox_reg[i] <= ox_reg[i-1];
        end
    end

    spm_place u_place_x (
        .clk    (clk),
        .v      (vx_s5_reg),
        .centre ({cfg.weff, 3'b000}),
        .minwh  (cfg.minwh),
        .pos    (px)
    );

    spm_place u_place_y (
        .clk    (clk),
        .v      (vy_s5_reg),
        .centre ({cfg.heff, 3'b000}),
        .minwh  (cfg.minwh),
        .pos    (py)
    );

    assign res_wr          = vld_reg[LAT];
    assign res.point_index = meta_reg[LAT].pidx;
    assign res.x_pos       = meta_reg[LAT].vec ? px : ox_reg[LAT];
    assign res.y_pos       = meta_reg[LAT].vec ? py : oy_reg[LAT];
    assign res.last_of_run = meta_reg[LAT].last;

endmodule

`default_nettype wire

>>> rtl/scope_point_mapper_core.sv
// Scope point mapper: stereo sample pairs in, screen points out.
// Input channel: push/full. A word (left_sample, right_sample, sample_index)
//   is taken at a rising edge with push high and full low.
// Output channel: empty/pop. While empty is low the oldest point is on
//   point_index/x_pos/y_pos/last_of_run; pop with empty low takes it.
// Config port: cfg_write, cfg_index, cfg_data; written at once, no read-back.
//   Write only while the block is idle; out-of-list indices are ignored.
// Oscilloscope mode: an even index gives two words (left, then right);
//   odd indices and indices past the frame give none.
// Vectorscope mode: one word per in-frame index.
// Path: a pushed word passes the front register, the job queue, the back pipe
//   and the result queue; the right point of an oscilloscope pair follows the left.
// Throughput: the back end starts one point per cycle while the result queue has
//   room, so a vectorscope stream or a full oscilloscope frame (even and odd
//   indices) runs at one word per cycle; even indices alone, giving two points each, run slower.
// Receiver stall: the back end only starts a point for which the 16-word
//   result queue has room, then the 4-word job queue and the front
//   register fill and full rises. Nothing is lost or reordered.
// Reset: queues empty, registers to mode 0, split 0, gain 1.0, 640x480,
//   rotation cos 1.0 and sin 0.
`timescale 1ns / 1ps
`default_nettype none

module scope_point_mapper_core #(
    parameter int SAMPLES_PER_FRAME = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input queue side
    input  logic                             push,
    output logic                             full,
    input  logic signed [15:0]               left_sample,
    input  logic signed [15:0]               right_sample,
    input  logic [9:0]                       sample_index,
    // result queue side
    output logic                             empty,
    input  logic                             pop,
    output logic [9:0]                       point_index,
    output logic [15:0]                      x_pos,
    output logic [15:0]                      y_pos,
    output logic                             last_of_run,
    // configuration
    input  logic                             cfg_write,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import spm_pkg::*;

    // configuration registers
    logic               mode_reg;
    logic               split_reg;
    logic [15:0]        gain_reg;
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;

    cfg_t       cfg;
    logic [11:0] weff;
    logic [11:0] heff;

    // front to job queue
    logic job_wr;
    job_t job_in;
    logic jq_full;

    // job queue to back
    job_t job_head;
    logic jq_empty;
    logic job_pop;

    // back to result queue
    logic res_wr;
    res_t res_in;
    logic rq_full;
    res_t res_head;
    logic res_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            split_reg  <= 1'b0;
            gain_reg   <= 16'd2048;
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            cos_reg    <= 16'sd16384;
            sin_reg    <= 16'sd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCOPE_MODE:   mode_reg   <= cfg_data[0];
                REG_STEREO_SPLIT: split_reg  <= cfg_data[0];
                REG_AUDIO_GAIN:   gain_reg   <= cfg_data;
                REG_WIDTH_PX:     width_reg  <= cfg_data[11:0];
                REG_HEIGHT_PX:    height_reg <= cfg_data[11:0];
                REG_ROT_COS:      cos_reg    <= $signed(cfg_data);
                REG_ROT_SIN:      sin_reg    <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // a zero size counts as one pixel
    assign weff = (width_reg == '0) ? 12'd1 : width_reg;
    assign heff = (height_reg == '0) ? 12'd1 : height_reg;

    always_comb
    begin
        cfg.split   = split_reg;
        cfg.gain    = gain_reg;
        cfg.weff    = weff;
        cfg.heff    = heff;
        cfg.minwh   = (weff < heff) ? weff : heff;
        cfg.rot_cos = cos_reg;
        cfg.rot_sin = sin_reg;
    end

    // front: takes words, drops those that make no point
    spm_front #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .sample_index (sample_index),
        .vec_mode     (mode_reg),
        .job_wr       (job_wr),
        .job          (job_in),
        .job_full     (jq_full)
    );

    spm_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (jq_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (jq_empty)
    );

    // back: fixed-latency arithmetic pipe, credit-gated, never stalls
    spm_back #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (job_head),
        .job_empty (jq_empty),
        .job_pop   (job_pop),
        .res_taken (res_taken),
        .res_wr    (res_wr),
        .res       (res_in)
    );

    spm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (rq_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign res_taken   = pop && !empty;
    assign point_index = res_head.point_index;
    assign x_pos       = res_head.x_pos;
    assign y_pos       = res_head.y_pos;
    assign last_of_run = res_head.last_of_run;

    // credits must keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_wr && rq_full))
        else $error("result word written into a full queue");

    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_wr && jq_full))
        else $error("job written into a full queue");

    a_job_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_pop && jq_empty))
        else $error("job taken from an empty queue");

endmodule

`default_nettype wire
